[hdl/tgb_pkg.sv]
// Shared constants, types and status codes for the triangle tangent basis pipeline.
`timescale 1ns / 1ps

package tgb_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int UV_BITS        = 16;
    localparam int LANES          = 3;
    localparam int NORM_BITS      = 30;
    localparam int SUM_BITS       = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS      = NORM_BITS + 1;
    localparam int FRAC_BITS      = 14;
    localparam int Q_BITS         = FRAC_BITS + 1;
    localparam int NUM_BITS       = NORM_BITS + FRAC_BITS + 1;
    localparam int OUT_LANE       = 16;

    localparam logic [Q_BITS-1:0] OUT_ONE = Q_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DET_ZERO = 2'd1,
        ST_ZERO_LEN = 2'd2
    } t_status;

    typedef struct packed {
        logic             det_zero;
        logic             vec_zero;
        logic [LANES-1:0] neg;
    } t_flags;

    typedef logic [LANES-1:0][NORM_BITS-1:0] t_nvec;

endpackage

[hdl/tgb_front.sv]
// Front end: edge and UV deltas, cross products, determinant sign and lane magnitudes.
`timescale 1ns / 1ps

module tgb_front
    import tgb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [47:0]                      i_pos_a,
    input  logic [47:0]                      i_pos_b,
    input  logic [47:0]                      i_pos_c,
    input  logic [31:0]                      i_uv_a,
    input  logic [31:0]                      i_uv_b,
    input  logic [31:0]                      i_uv_c,
    output logic                             o_valid,
    output logic [LANES-1:0][COORD_BITS+18:0] o_mag_t,
    output logic [LANES-1:0][COORD_BITS+18:0] o_mag_b,
    output t_flags                           o_flags_t,
    output t_flags                           o_flags_b
);

    localparam int EXT_BITS  = LANES * COORD_BITS;
    localparam int DP_BITS   = COORD_BITS + 1;
    localparam int DUV_BITS  = UV_BITS + 1;
    localparam int PROD_BITS = DP_BITS + DUV_BITS;
    localparam int RAW_BITS  = PROD_BITS + 1;
    localparam int DPROD     = 2 * DUV_BITS;
    localparam int DET_BITS  = DPROD + 1;

    logic [EXT_BITS-1:0] ext_a, ext_b, ext_c;

    assign ext_a = EXT_BITS'(i_pos_a);
    assign ext_b = EXT_BITS'(i_pos_b);
    assign ext_c = EXT_BITS'(i_pos_c);

    // Stage 1: deltas.
    logic signed [DP_BITS-1:0]  n_dp1 [LANES];
    logic signed [DP_BITS-1:0]  n_dp2 [LANES];
    logic signed [DP_BITS-1:0]  r_dp1 [LANES];
    logic signed [DP_BITS-1:0]  r_dp2 [LANES];
    logic signed [DUV_BITS-1:0] n_du1, n_dv1, n_du2, n_dv2;
    logic signed [DUV_BITS-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic                       r_v1;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_dp1[i] = $signed({ext_b[i*COORD_BITS+COORD_BITS-1], ext_b[i*COORD_BITS +: COORD_BITS]})
                     - $signed({ext_a[i*COORD_BITS+COORD_BITS-1], ext_a[i*COORD_BITS +: COORD_BITS]});
            n_dp2[i] = $signed({ext_c[i*COORD_BITS+COORD_BITS-1], ext_c[i*COORD_BITS +: COORD_BITS]})
                     - $signed({ext_a[i*COORD_BITS+COORD_BITS-1], ext_a[i*COORD_BITS +: COORD_BITS]});
        end
        n_du1 = $signed({i_uv_b[UV_BITS-1], i_uv_b[UV_BITS-1:0]})
              - $signed({i_uv_a[UV_BITS-1], i_uv_a[UV_BITS-1:0]});
        n_dv1 = $signed({i_uv_b[2*UV_BITS-1], i_uv_b[2*UV_BITS-1:UV_BITS]})
              - $signed({i_uv_a[2*UV_BITS-1], i_uv_a[2*UV_BITS-1:UV_BITS]});
        n_du2 = $signed({i_uv_c[UV_BITS-1], i_uv_c[UV_BITS-1:0]})
              - $signed({i_uv_a[UV_BITS-1], i_uv_a[UV_BITS-1:0]});
        n_dv2 = $signed({i_uv_c[2*UV_BITS-1], i_uv_c[2*UV_BITS-1:UV_BITS]})
              - $signed({i_uv_a[2*UV_BITS-1], i_uv_a[2*UV_BITS-1:UV_BITS]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_dp1 <= n_dp1;
            r_dp2 <= n_dp2;
            r_du1 <= n_du1;
            r_dv1 <= n_dv1;
            r_du2 <= n_du2;
            r_dv2 <= n_dv2;
        end
    end

    // Stage 2: partial products.
    logic signed [PROD_BITS-1:0] r_tp1 [LANES];
    logic signed [PROD_BITS-1:0] r_tp2 [LANES];
    logic signed [PROD_BITS-1:0] r_bp1 [LANES];
    logic signed [PROD_BITS-1:0] r_bp2 [LANES];
    logic signed [DPROD-1:0]     r_dt1, r_dt2;
    logic                        r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_tp1[i] <= PROD_BITS'(r_dp1[i]) * PROD_BITS'(r_dv2);
                r_tp2[i] <= PROD_BITS'(r_dp2[i]) * PROD_BITS'(r_dv1);
                r_bp1[i] <= PROD_BITS'(r_dp2[i]) * PROD_BITS'(r_du1);
                r_bp2[i] <= PROD_BITS'(r_dp1[i]) * PROD_BITS'(r_du2);
            end
            r_dt1 <= DPROD'(r_du1) * DPROD'(r_dv2);
            r_dt2 <= DPROD'(r_dv1) * DPROD'(r_du2);
        end
    end

    // Stage 3: raw tangent, raw bitangent and determinant.
    logic signed [RAW_BITS-1:0] r_t [LANES];
    logic signed [RAW_BITS-1:0] r_b [LANES];
    logic signed [DET_BITS-1:0] n_det;
    logic                       r_det_zero, r_det_neg, r_v3;

    assign n_det = DET_BITS'(r_dt1) - DET_BITS'(r_dt2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_t[i] <= RAW_BITS'(r_tp1[i]) - RAW_BITS'(r_tp2[i]);
                r_b[i] <= RAW_BITS'(r_bp1[i]) - RAW_BITS'(r_bp2[i]);
            end
            r_det_zero <= (n_det == '0);
            r_det_neg  <= n_det[DET_BITS-1];
        end
    end

    // Stage 4: magnitudes. A negative determinant only flips the sign bit.
    logic [LANES-1:0][RAW_BITS-1:0] n_mag_t, n_mag_b;
    t_flags                         n_fl_t, n_fl_b;
    logic                           r_v4;

    always_comb begin
        n_fl_t.det_zero = r_det_zero;
        n_fl_b.det_zero = r_det_zero;
        n_fl_t.vec_zero = 1'b1;
        n_fl_b.vec_zero = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            n_mag_t[i]   = r_t[i][RAW_BITS-1] ? RAW_BITS'(-r_t[i]) : RAW_BITS'(r_t[i]);
            n_mag_b[i]   = r_b[i][RAW_BITS-1] ? RAW_BITS'(-r_b[i]) : RAW_BITS'(r_b[i]);
            n_fl_t.neg[i] = r_t[i][RAW_BITS-1] ^ r_det_neg;
            n_fl_b.neg[i] = r_b[i][RAW_BITS-1] ^ r_det_neg;
            if (r_t[i] != '0) begin
                n_fl_t.vec_zero = 1'b0;
            end
            if (r_b[i] != '0) begin
                n_fl_b.vec_zero = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            o_mag_t   <= n_mag_t;
            o_mag_b   <= n_mag_b;
            o_flags_t <= n_fl_t;
            o_flags_b <= n_fl_b;
        end
    end

    assign o_valid = r_v4;

endmodule

[hdl/tgb_norm.sv]
// Block-floating normalization of one vector and the sum of its squared lanes.
`timescale 1ns / 1ps

module tgb_norm
    import tgb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [LANES-1:0][COORD_BITS+18:0] i_mag,
    input  t_flags                           i_flags,
    output logic                             o_valid,
    output logic [SUM_BITS-1:0]              o_sum,
    output t_nvec                            o_nm,
    output t_flags                           o_flags
);

    localparam int MAG_BITS  = COORD_BITS + 19;
    localparam int LEAD_BITS = $clog2(MAG_BITS);
    localparam int WIDE_BITS = MAG_BITS + NORM_BITS - 1;
    localparam int SQ_BITS   = 2 * NORM_BITS;

    // Stage 1: position of the leading one over all lanes.
    logic [MAG_BITS-1:0]            n_or;
    logic [LEAD_BITS-1:0]           n_lead, r_lead;
    logic [LANES-1:0][MAG_BITS-1:0] r_mag;
    t_flags                         r_fl1;
    logic                           r_v1;

    always_comb begin
        n_or   = i_mag[0] | i_mag[1] | i_mag[2];
        n_lead = '0;
        for (int k = 0; k < MAG_BITS; k++) begin
            if (n_or[k]) begin
                n_lead = LEAD_BITS'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_mag  <= i_mag;
            r_lead <= n_lead;
            r_fl1  <= i_flags;
        end
    end

    // Stage 2: shift so that the largest lane lands in [2^29, 2^30).
    logic [WIDE_BITS-1:0] n_wide [LANES];
    t_nvec                n_nm, r_nm2;
    t_flags               r_fl2;
    logic                 r_v2;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_wide[i] = {r_mag[i], {(NORM_BITS-1){1'b0}}} >> r_lead;
            n_nm[i]   = n_wide[i][NORM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_nm2 <= n_nm;
            r_fl2 <= r_fl1;
        end
    end

    // Stage 3: squares.
    logic [SQ_BITS-1:0] r_sq [LANES];
    t_nvec              r_nm3;
    t_flags             r_fl3;
    logic               r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_sq[i] <= SQ_BITS'(r_nm2[i]) * SQ_BITS'(r_nm2[i]);
            end
            r_nm3 <= r_nm2;
            r_fl3 <= r_fl2;
        end
    end

    // Stage 4: sum of squares.
    logic r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            o_sum   <= SUM_BITS'(r_sq[0]) + SUM_BITS'(r_sq[1]) + SUM_BITS'(r_sq[2]);
            o_nm    <= r_nm3;
            o_flags <= r_fl3;
        end
    end

    assign o_valid = r_v4;

endmodule

[hdl/tgb_isqrt.sv]
// Pipelined integer square root, one root bit per stage, with the lanes carried alongside.
`timescale 1ns / 1ps

module tgb_isqrt
    import tgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SUM_BITS-1:0]  i_sum,
    input  t_nvec                i_nm,
    input  t_flags               i_flags,
    output logic                 o_valid,
    output logic [ROOT_BITS-1:0] o_root,
    output t_nvec                o_nm,
    output t_flags               o_flags
);

    logic [SUM_BITS-1:0]  r_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS+1];
    t_nvec                r_nm   [ROOT_BITS+1];
    t_flags               r_fl   [ROOT_BITS+1];
    logic                 r_v    [ROOT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= i_sum;
            r_root[0] <= '0;
            r_nm[0]   <= i_nm;
            r_fl[0]   <= i_flags;
        end
    end

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_step
        localparam int B = ROOT_BITS - 1 - g;

        logic [SUM_BITS:0] trial;
        logic              fits;

        // Only root bits above B are set, so the two terms never overlap.
        always_comb begin
            trial = ((SUM_BITS+1)'(r_root[g]) << (B + 1)) | ((SUM_BITS+1)'(1) << (2 * B));
            fits  = ({1'b0, r_rem[g]} >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_rem[g+1]  <= fits ? SUM_BITS'({1'b0, r_rem[g]} - trial) : r_rem[g];
                r_root[g+1] <= fits ? (r_root[g] | (ROOT_BITS'(1) << B)) : r_root[g];
                r_nm[g+1]   <= r_nm[g];
                r_fl[g+1]   <= r_fl[g];
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS];
    assign o_root  = r_root[ROOT_BITS];
    assign o_nm    = r_nm[ROOT_BITS];
    assign o_flags = r_fl[ROOT_BITS];

endmodule

[hdl/tgb_div.sv]
// Pipelined restoring divider: rounded lane / root in Q1.14, three lanes side by side.
`timescale 1ns / 1ps

module tgb_div
    import tgb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ROOT_BITS-1:0]         i_root,
    input  t_nvec                        i_nm,
    input  t_flags                       i_flags,
    output logic                         o_valid,
    output logic [LANES-1:0][Q_BITS-1:0] o_q,
    output t_flags                       o_flags
);

    logic [LANES-1:0][NUM_BITS-1:0] r_rem [Q_BITS+1];
    logic [LANES-1:0][Q_BITS-1:0]   r_q   [Q_BITS+1];
    logic [ROOT_BITS-1:0]           r_den [Q_BITS+1];
    t_flags                         r_fl  [Q_BITS+1];
    logic                           r_v   [Q_BITS+1];

    // The numerator carries half the root so the quotient comes out rounded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_rem[0][i] <= NUM_BITS'({i_nm[i], {FRAC_BITS{1'b0}}})
                             + NUM_BITS'(i_root >> 1);
            end
            r_q[0]   <= '0;
            r_den[0] <= i_root;
            r_fl[0]  <= i_flags;
        end
    end

    for (genvar g = 0; g < Q_BITS; g++) begin : g_step
        localparam int B = Q_BITS - 1 - g;

        logic [NUM_BITS:0] sub;
        logic [LANES-1:0]  fits;

        always_comb begin
            sub = (NUM_BITS+1)'(r_den[g]) << B;
            for (int i = 0; i < LANES; i++) begin
                fits[i] = ({1'b0, r_rem[g][i]} >= sub);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                for (int i = 0; i < LANES; i++) begin
                    r_rem[g+1][i] <= fits[i] ? NUM_BITS'({1'b0, r_rem[g][i]} - sub)
                                             : r_rem[g][i];
                    r_q[g+1][i]   <= fits[i] ? (r_q[g][i] | (Q_BITS'(1) << B)) : r_q[g][i];
                end
                r_den[g+1] <= r_den[g];
                r_fl[g+1]  <= r_fl[g];
            end
        end
    end

    assign o_valid = r_v[Q_BITS];
    assign o_q     = r_q[Q_BITS];
    assign o_flags = r_fl[Q_BITS];

endmodule

[hdl/triangle_tangent_basis.sv]
// Top level of the per-triangle tangent and bitangent unit.
//
//  Channel   Valid     Stall     Payload
//  input     i_valid   o_stall   i_pos_a, i_pos_b, i_pos_c, i_uv_a, i_uv_b, i_uv_c
//  output    o_valid   i_stall   o_tangent_unit, o_bitangent_unit, o_status
//
// One triangle is taken every cycle while o_stall is low.
// The depth is set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage). All stages advance together and hold when the
// output register is full and stalled; no request is dropped or repeated.
// Reset clears only the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module triangle_tangent_basis
    import tgb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_pos_a,
    input  logic [47:0] i_pos_b,
    input  logic [47:0] i_pos_c,
    input  logic [31:0] i_uv_a,
    input  logic [31:0] i_uv_b,
    input  logic [31:0] i_uv_c,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_tangent_unit,
    output logic [47:0] o_bitangent_unit,
    output logic [1:0]  o_status
);

    logic en;
    logic r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    logic                             fr_v;
    logic [LANES-1:0][COORD_BITS+18:0] fr_mag_t, fr_mag_b;
    t_flags                           fr_fl_t, fr_fl_b;

    tgb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_pos_a   (i_pos_a),
        .i_pos_b   (i_pos_b),
        .i_pos_c   (i_pos_c),
        .i_uv_a    (i_uv_a),
        .i_uv_b    (i_uv_b),
        .i_uv_c    (i_uv_c),
        .o_valid   (fr_v),
        .o_mag_t   (fr_mag_t),
        .o_mag_b   (fr_mag_b),
        .o_flags_t (fr_fl_t),
        .o_flags_b (fr_fl_b)
    );

    logic                         nm_v_t, nm_v_b, sq_v_t, sq_v_b, dv_v_t, dv_v_b;
    logic [SUM_BITS-1:0]          sum_t, sum_b;
    t_nvec                        nm_t, nm_b, sq_nm_t, sq_nm_b;
    t_flags                       nm_fl_t, nm_fl_b, sq_fl_t, sq_fl_b, dv_fl_t, dv_fl_b;
    logic [ROOT_BITS-1:0]         root_t, root_b;
    logic [LANES-1:0][Q_BITS-1:0] q_t, q_b;

    tgb_norm #(.COORD_BITS(COORD_BITS)) u_norm_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(fr_v), .i_mag(fr_mag_t), .i_flags(fr_fl_t),
        .o_valid(nm_v_t), .o_sum(sum_t), .o_nm(nm_t), .o_flags(nm_fl_t)
    );

    tgb_norm #(.COORD_BITS(COORD_BITS)) u_norm_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(fr_v), .i_mag(fr_mag_b), .i_flags(fr_fl_b),
        .o_valid(nm_v_b), .o_sum(sum_b), .o_nm(nm_b), .o_flags(nm_fl_b)
    );

    tgb_isqrt u_isqrt_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(nm_v_t), .i_sum(sum_t), .i_nm(nm_t), .i_flags(nm_fl_t),
        .o_valid(sq_v_t), .o_root(root_t), .o_nm(sq_nm_t), .o_flags(sq_fl_t)
    );

    tgb_isqrt u_isqrt_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(nm_v_b), .i_sum(sum_b), .i_nm(nm_b), .i_flags(nm_fl_b),
        .o_valid(sq_v_b), .o_root(root_b), .o_nm(sq_nm_b), .o_flags(sq_fl_b)
    );

    tgb_div u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_v_t), .i_root(root_t), .i_nm(sq_nm_t), .i_flags(sq_fl_t),
        .o_valid(dv_v_t), .o_q(q_t), .o_flags(dv_fl_t)
    );

    tgb_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_v_b), .i_root(root_b), .i_nm(sq_nm_b), .i_flags(sq_fl_b),
        .o_valid(dv_v_b), .o_q(q_b), .o_flags(dv_fl_b)
    );

    // Output stage: cap, apply signs, and force zero vectors on any error.
    t_status     n_status, r_status;
    logic [47:0] n_tan, n_bit, r_tan, r_bit;
    logic [Q_BITS-1:0]   cap_t, cap_b;
    logic [OUT_LANE-1:0] val_t, val_b;

    always_comb begin
        n_tan = '0;
        n_bit = '0;
        cap_t = '0;
        cap_b = '0;
        val_t = '0;
        val_b = '0;
        if (dv_fl_t.det_zero) begin
            n_status = ST_DET_ZERO;
        end else if (dv_fl_t.vec_zero || dv_fl_b.vec_zero) begin
            n_status = ST_ZERO_LEN;
        end else begin
            n_status = ST_OK;
        end
        for (int i = 0; i < LANES; i++) begin
            cap_t = (q_t[i] > OUT_ONE) ? OUT_ONE : q_t[i];
            cap_b = (q_b[i] > OUT_ONE) ? OUT_ONE : q_b[i];
            val_t = dv_fl_t.neg[i] ? OUT_LANE'(-OUT_LANE'(cap_t)) : OUT_LANE'(cap_t);
            val_b = dv_fl_b.neg[i] ? OUT_LANE'(-OUT_LANE'(cap_b)) : OUT_LANE'(cap_b);
            if (n_status == ST_OK) begin
                n_tan[i*OUT_LANE +: OUT_LANE] = val_t;
                n_bit[i*OUT_LANE +: OUT_LANE] = val_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v_t;
        end
        if (en) begin
            r_status <= n_status;
            r_tan    <= n_tan;
            r_bit    <= n_bit;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_tangent_unit   = r_tan;
    assign o_bitangent_unit = r_bit;
    assign o_status         = r_status;

    // The two vector paths must stay in lockstep.
    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_v_t == dv_v_b)
        else $error("tangent and bitangent paths out of step");

    a_det_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_v_t |-> (dv_fl_t.det_zero == dv_fl_b.det_zero))
        else $error("determinant flag differs between paths");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_tan == '0 && r_bit == '0))
        else $error("error result carries nonzero vectors");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK) |-> (r_tan != '0 && r_bit != '0))
        else $error("good result carries a zero vector");

endmodule

[sim/triangle_tangent_basis_tb.sv]
// Self-checking testbench for the triangle tangent and bitangent unit.
`timescale 1ns / 1ps

module triangle_tangent_basis_tb;
    import tgb_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  LATENCY      = 57;
    localparam int  HOLD_CYCLES  = 300;

    typedef struct {
        logic [47:0] tangent;
        logic [47:0] bitangent;
        t_status     status;
    } t_basis;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [47:0] i_pos_a, i_pos_b, i_pos_c;
    logic [31:0] i_uv_a, i_uv_b, i_uv_c;
    logic        o_valid;
    logic        i_stall;
    logic [47:0] o_tangent_unit, o_bitangent_unit;
    logic [1:0]  o_status;

    t_basis pending_basis[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;

    triangle_tangent_basis DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_a(i_pos_a), .i_pos_b(i_pos_b), .i_pos_c(i_pos_c),
        .i_uv_a(i_uv_a), .i_uv_b(i_uv_b), .i_uv_c(i_uv_c),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tangent_unit(o_tangent_unit), .o_bitangent_unit(o_bitangent_unit),
        .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint lane16(input logic [47:0] word, input int idx);
        return longint'($signed(word[idx*16 +: 16]));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Block-floating normalization to Q1.14 lanes; returns 0 for a zero vector.
    function automatic bit unit_vector(input longint c[3], output logic [47:0] vec_out);
        longint unsigned mag[3];
        longint unsigned m, s, r, q;
        bit neg[3];
        m = 0;
        s = 0;
        vec_out = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            mag[i] = neg[i] ? longint'(-c[i]) : c[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (r >> 1)) / r;
            if (q > 16384) q = 16384;
            if (neg[i] && q != 0) q = (64'h10000 - q) & 64'hFFFF;
            vec_out[i*16 +: 16] = q[15:0];
        end
        return 1'b1;
    endfunction

    function automatic t_basis predict_basis(
        input logic [47:0] pa, pb, pc, input logic [31:0] ua, ub, uc);
        t_basis res;
        longint dp1[3], dp2[3], tv[3], bv[3];
        longint du1, dv1, du2, dv2, det;
        logic [47:0] tu, bu;
        res.tangent = '0;
        res.bitangent = '0;
        res.status = ST_OK;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = lane16(pb, i) - lane16(pa, i);
            dp2[i] = lane16(pc, i) - lane16(pa, i);
        end
        du1 = lane16(ub, 0) - lane16(ua, 0);
        dv1 = lane16(ub, 1) - lane16(ua, 1);
        du2 = lane16(uc, 0) - lane16(ua, 0);
        dv2 = lane16(uc, 1) - lane16(ua, 1);
        det = du1 * dv2 - dv1 * du2;
        if (det == 0) begin
            res.status = ST_DET_ZERO;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            tv[i] = dp1[i] * dv2 - dp2[i] * dv1;
            bv[i] = dp2[i] * du1 - dp1[i] * du2;
            if (det < 0) begin
                tv[i] = -tv[i];
                bv[i] = -bv[i];
            end
        end
        if (!unit_vector(tv, tu) || !unit_vector(bv, bu)) begin
            res.status = ST_ZERO_LEN;
        end else begin
            res.tangent = tu;
            res.bitangent = bu;
        end
        return res;
    endfunction

    // Offers one triangle, with a random gap first, and records its basis once taken.
    task automatic send_triangle(
        input logic [47:0] pa, pb, pc, input logic [31:0] ua, ub, uc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_a <= pa;
        i_pos_b <= pb;
        i_pos_c <= pc;
        i_uv_a  <= ua;
        i_uv_b  <= ub;
        i_uv_c  <= uc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_basis.push_back(predict_basis(pa, pb, pc, ua, ub, uc));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_basis.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack_pos(input int x, y, z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [47:0] rand_pos();
        return 48'({$urandom, $urandom});
    endfunction

    // Vertex b and c sit near a so that edges stay short and well formed.
    function automatic logic [47:0] near_pos(input logic [47:0] base, input int spread);
        logic [47:0] p;
        for (int i = 0; i < 3; i++)
            p[i*16 +: 16] = base[i*16 +: 16] + 16'($urandom_range(2 * spread) - spread);
        return p;
    endfunction

    task automatic test_directed();
        logic [47:0] pmax, pmin;
        pmax = pack_pos('h7FFF, 'h7FFF, 'h7FFF);
        pmin = pack_pos('h8000, 'h8000, 'h8000);
        // All zero: the UV determinant is zero.
        send_triangle('0, '0, '0, '0, '0, '0);
        // Extreme positions and UVs, both determinant signs.
        send_triangle(pmin, pmax, '0, 32'h8000_8000, 32'h8000_7FFF, 32'h7FFF_8000);
        send_triangle(pmax, pmin, pack_pos('h7FFF, 'h8000, 0),
                      32'h7FFF_7FFF, 32'h8000_7FFF, 32'h7FFF_8000);
        send_triangle('1, '0, pmax, 32'h0, 32'h0000_1000, 32'h0000_1000);
        send_triangle(pack_pos(0, 0, 0), pack_pos(256, 0, 0), pack_pos(0, 256, 0),
                      32'h0, 32'h0000_1000, 32'h1000_0000);
        send_triangle(pack_pos(0, 0, 0), pack_pos(256, 0, 0), pack_pos(0, 256, 0),
                      32'h0, 32'h1000_0000, 32'h0000_1000);
        // Collinear UVs: zero determinant with nonzero edges.
        send_triangle(pack_pos(1, 2, 3), pack_pos(9, 8, 7), pack_pos(-5, 4, 0),
                      32'h0, 32'h0100_0100, 32'h0200_0200);
        // Degenerate positions: zero-length tangent and bitangent.
        send_triangle(pmax, pmax, pmax, 32'h0, 32'h0000_1000, 32'h1000_0000);
        // Flat edges along x only: bitangent zero-length only on one side.
        send_triangle(pack_pos(0, 0, 0), pack_pos(100, 0, 0), pack_pos(0, 0, 0),
                      32'h0, 32'h0000_1000, 32'h1000_0000);
        // A huge component beside tiny ones truncates them to zero, either sign.
        send_triangle(pack_pos(0, 0, 0), pack_pos('h7FFF, 1, 'hFFFF),
                      pack_pos(0, 0, 0), 32'h0, 32'h0000_7FFF, 32'h7FFF_0000);
        send_triangle(pack_pos('h8000, 0, 0), pack_pos('h7FFF, 'hFFFF, 1),
                      pack_pos('h8000, 1, 0), 32'h8000_8000, 32'h8000_7FFF,
                      32'h7FFF_8000);
        // Tiny vector that needs a large left shift.
        send_triangle(pack_pos(0, 0, 0), pack_pos(1, 0, 0), pack_pos(0, 1, 0),
                      32'h0, 32'h0000_0001, 32'h0001_0000);
        send_triangle(pack_pos(0, 0, 0), pack_pos(1, 1, 1), pack_pos('hFFFF, 1, 0),
                      32'h0, 32'h0001_0001, 32'hFFFF_0001);
        wait_drained();
    endtask

    task automatic random_triangle();
        logic [47:0] pa, pb, pc;
        logic [31:0] ua, ub, uc;
        int kind;
        kind = $urandom_range(9);
        pa = rand_pos();
        ua = $urandom;
        if (kind < 4) begin
            pb = near_pos(pa, 2048);
            pc = near_pos(pa, 2048);
            ub = ua + {16'($urandom_range(4096)), 16'($urandom_range(4096))};
            uc = ua - {16'($urandom_range(4096)), 16'($urandom_range(4096))};
        end else if (kind < 7) begin
            pb = rand_pos();
            pc = rand_pos();
            ub = $urandom;
            uc = $urandom;
        end else if (kind == 7) begin
            pb = near_pos(pa, 3);
            pc = near_pos(pa, 3);
            ub = ua + {16'($urandom_range(2)), 16'($urandom_range(2))};
            uc = ua + {16'($urandom_range(2)), 16'($urandom_range(2))};
        end else if (kind == 8) begin
            // Degenerate UVs and a repeated vertex.
            pb = rand_pos();
            pc = $urandom_range(1) ? pa : pb;
            ub = $urandom;
            uc = $urandom_range(1) ? ua : ub;
        end else begin
            pb = near_pos(pa, 1);
            pc = pb;
            ub = $urandom;
            uc = $urandom;
        end
        send_triangle(pa, pb, pc, ua, ub, uc);
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            random_triangle();
            // Runs without any idling now and then.
            if (n % 100 == 50) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (n % 100 == 80) begin
                send_idle_pct = send_pct;
                recv_idle_pct = recv_pct;
            end
        end
        wait_drained();
    endtask

    // The receiver holds off long enough that the pipeline fills and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        for (int n = 0; n < 120; n++) random_triangle();
        wait_drained();
    endtask

    // The sender stops mid-stream until every result is back, then resumes.
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 20;
        for (int n = 0; n < 40; n++) random_triangle();
        wait_drained();
        for (int n = 0; n < 40; n++) random_triangle();
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_basis want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_basis.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_basis.pop_front();
                if (o_tangent_unit !== want.tangent) begin
                    $error("tangent_unit expected %h got %h", want.tangent, o_tangent_unit);
                    fail_count++;
                end
                if (o_bitangent_unit !== want.bitangent) begin
                    $error("bitangent_unit expected %h got %h", want.bitangent,
                           o_bitangent_unit);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_pos_a <= '0;
        i_pos_b <= '0;
        i_pos_c <= '0;
        i_uv_a  <= '0;
        i_uv_b  <= '0;
        i_uv_c  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(380, 15, 74);
        test_random(380, 74, 15);
        test_backpressure();
        test_drain_pause();
        test_random(200, 0, 0);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tgb_pkg.sv
hdl/tgb_front.sv
hdl/tgb_norm.sv
hdl/tgb_isqrt.sv
hdl/tgb_div.sv
hdl/triangle_tangent_basis.sv
sim/triangle_tangent_basis_tb.sv
